// ----- hw/rtl/planar_odometry_integrator_macros.svh -----
// ----------------------------------------------------------------------------
// Planar odometry integrator assertion macros
// Shared helpers for the concurrent checks of the odometry block.
// ----------------------------------------------------------------------------
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define POI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define POI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/poi_pkg.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Widths, reset values, the CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int POS_BITS_DEF   = 48;
  localparam int HEAD_W         = 17;
  localparam int ENC_W          = 16;
  localparam int SCALE_W        = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd16777;

  localparam int PHASE_W      = 32;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [PHASE_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Queue depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_INTEGRATE = 1'b0,
    CMD_SET       = 1'b1
  } poi_cmd_t;

  typedef struct packed {
    logic       valid;
    logic       is_set;
    logic [1:0] quad;
  } poi_qctl_t;

endpackage

// ----- hw/rtl/poi_ifs.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface poi_in_if #(
  parameter int ANGLE_BITS = poi_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS   = poi_pkg::POS_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [poi_pkg::ENC_W-1:0]  enc_x_pulses;
  logic signed [poi_pkg::ENC_W-1:0]  enc_y_pulses;
  logic [ANGLE_BITS-1:0]             heading_angle;
  logic signed [poi_pkg::HEAD_W-1:0] heading_degrees;
  logic signed [POS_BITS-1:0]        set_x;
  logic signed [POS_BITS-1:0]        set_y;
  logic signed [poi_pkg::HEAD_W-1:0] set_heading;

  modport source (
    output valid, command, enc_x_pulses, enc_y_pulses, heading_angle,
           heading_degrees, set_x, set_y, set_heading,
    input  ready
  );
  modport sink (
    input  valid, command, enc_x_pulses, enc_y_pulses, heading_angle,
           heading_degrees, set_x, set_y, set_heading,
    output ready
  );
endinterface

interface poi_out_if #(
  parameter int POS_BITS = poi_pkg::POS_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [POS_BITS-1:0]        pos_x;
  logic signed [POS_BITS-1:0]        pos_y;
  logic signed [poi_pkg::HEAD_W-1:0] heading_out;
  logic                              set_done;

  modport source (output valid, pos_x, pos_y, heading_out, set_done, input ready);
  modport sink (input valid, pos_x, pos_y, heading_out, set_done, output ready);
endinterface

interface poi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [poi_pkg::SCALE_W-1:0]   pulse_scale;

  modport source (output valid, pulse_scale, input ready);
  modport sink (input valid, pulse_scale, output ready);
endinterface

// ----- hw/rtl/poi_front.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator front end
// Accepts requests, derives the quadrant and residual angle, and queues them.
// ----------------------------------------------------------------------------
module poi_front #(
  parameter int ANGLE_BITS = poi_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS   = poi_pkg::POS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  poi_in_if.sink                              in_if,
  output poi_pkg::poi_qctl_t                  q_ctl,
  input  logic                                q_ready,
  output logic signed [poi_pkg::ENC_W-1:0]    q_ex,
  output logic signed [poi_pkg::ENC_W-1:0]    q_ey,
  output logic signed [poi_pkg::PHASE_W-1:0]  q_z0,
  output logic signed [poi_pkg::HEAD_W-1:0]   q_heading,
  output logic signed [POS_BITS-1:0]          q_set_x,
  output logic signed [POS_BITS-1:0]          q_set_y
);

  localparam int DEPTH = poi_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PH_W  = poi_pkg::PHASE_W;

  logic                                set_mem  [DEPTH];
  logic [1:0]                          quad_mem [DEPTH];
  logic signed [poi_pkg::ENC_W-1:0]    ex_mem   [DEPTH];
  logic signed [poi_pkg::ENC_W-1:0]    ey_mem   [DEPTH];
  logic signed [PH_W-1:0]              z0_mem   [DEPTH];
  logic signed [poi_pkg::HEAD_W-1:0]   head_mem [DEPTH];
  logic signed [POS_BITS-1:0]          sx_mem   [DEPTH];
  logic signed [POS_BITS-1:0]          sy_mem   [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             push_w;
  logic             pop_w;
  logic             is_set_w;
  logic [PH_W-1:0]  phase_w;
  logic [1:0]       quad_w;
  logic [PH_W-1:0]  z0_w;

  assign in_if.ready = (count_r != CNT_W'(DEPTH));
  assign push_w      = in_if.valid && in_if.ready;
  assign pop_w       = q_ctl.valid && q_ready;
  assign is_set_w    = (in_if.command == poi_pkg::CMD_SET);

  // The angle is split into a quarter turn and a residual within plus or minus
  // one eighth of a turn, which is what the rotation stage iterates on.
  assign phase_w = PH_W'(in_if.heading_angle) << (PH_W - ANGLE_BITS);
  assign quad_w  = phase_w[PH_W-1:PH_W-2] + {1'b0, phase_w[PH_W-3]};
  assign z0_w    = {{2{phase_w[PH_W-3]}}, phase_w[PH_W-3:0]};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_w) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (pop_w) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    priority if (push_w && !pop_w) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_w && !push_w) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_w) begin
      set_mem[wr_ptr_r]  <= is_set_w;
      quad_mem[wr_ptr_r] <= quad_w;
      ex_mem[wr_ptr_r]   <= in_if.enc_x_pulses;
      ey_mem[wr_ptr_r]   <= in_if.enc_y_pulses;
      z0_mem[wr_ptr_r]   <= z0_w;
      head_mem[wr_ptr_r] <= is_set_w ? in_if.set_heading : in_if.heading_degrees;
      sx_mem[wr_ptr_r]   <= in_if.set_x;
      sy_mem[wr_ptr_r]   <= in_if.set_y;
    end
  end

  assign q_ctl.valid  = (count_r != '0);
  assign q_ctl.is_set = set_mem[rd_ptr_r];
  assign q_ctl.quad   = quad_mem[rd_ptr_r];
  assign q_ex         = ex_mem[rd_ptr_r];
  assign q_ey         = ey_mem[rd_ptr_r];
  assign q_z0         = z0_mem[rd_ptr_r];
  assign q_heading    = head_mem[rd_ptr_r];
  assign q_set_x      = sx_mem[rd_ptr_r];
  assign q_set_y      = sy_mem[rd_ptr_r];

endmodule

// ----- hw/rtl/poi_back.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator back end
// Iterative CORDIC rotation, scaling, saturating accumulation and result register.
// ----------------------------------------------------------------------------
module poi_back #(
  parameter int POS_BITS = poi_pkg::POS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  poi_pkg::poi_qctl_t                  q_ctl,
  output logic                                q_ready,
  input  logic signed [poi_pkg::ENC_W-1:0]    q_ex,
  input  logic signed [poi_pkg::ENC_W-1:0]    q_ey,
  input  logic signed [poi_pkg::PHASE_W-1:0]  q_z0,
  input  logic signed [poi_pkg::HEAD_W-1:0]   q_heading,
  input  logic signed [POS_BITS-1:0]          q_set_x,
  input  logic signed [POS_BITS-1:0]          q_set_y,
  poi_cfg_if.sink                             cfg_if,
  poi_out_if.source                           out_if
);

  localparam int CW  = poi_pkg::CORDIC_W;
  localparam int EW  = poi_pkg::ENC_W;
  localparam int HW  = poi_pkg::HEAD_W;
  localparam int IW  = poi_pkg::ITER_W;
  localparam int MW  = CW + EW;
  localparam int VW  = 34;
  localparam int PW  = VW + poi_pkg::SCALE_W + 1;
  localparam int DW  = PW - poi_pkg::SCALE_W;
  localparam int SW  = ((POS_BITS > DW) ? POS_BITS : DW) + 1;

  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ROT  = 8'b0000_0010,
    S_MULX = 8'b0000_0100,
    S_MULY = 8'b0000_1000,
    S_SUMY = 8'b0001_0000,
    S_SCLY = 8'b0010_0000,
    S_ACCY = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0] iter_r;

  logic [poi_pkg::SCALE_W-1:0] scale_r;
  logic signed [POS_BITS-1:0]  x_acc_r;
  logic signed [POS_BITS-1:0]  y_acc_r;
  logic signed [HW-1:0]        heading_r;

  logic                 cur_set_r;
  logic [1:0]           quad_r;
  logic signed [EW-1:0] ex_r;
  logic signed [EW-1:0] ey_r;
  logic signed [HW-1:0] cur_head_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [CW-1:0] z_r;
  logic signed [MW-1:0] pa_r;
  logic signed [MW-1:0] pb_r;
  logic signed [VW-1:0] vx_r;
  logic signed [VW-1:0] vy_r;
  logic signed [PW-1:0] pr_r;

  logic                        out_valid_r;
  logic signed [POS_BITS-1:0]  pos_x_r;
  logic signed [POS_BITS-1:0]  pos_y_r;
  logic signed [HW-1:0]        head_out_r;
  logic                        set_done_r;

  logic                 pop_w;
  logic                 out_load_w;
  logic signed [CW-1:0] dx_w;
  logic signed [CW-1:0] dy_w;
  logic signed [CW-1:0] atan_w;
  logic signed [CW-1:0] c_w;
  logic signed [CW-1:0] s_w;
  logic signed [CW-1:0] mc_w;
  logic signed [CW-1:0] md_w;
  logic signed [MW:0]   comb_w;
  logic signed [MW:0]   rnd_w;
  logic signed [VW-1:0] v16_w;
  logic signed [VW-1:0] ms_w;
  logic signed [PW-1:0] prr_w;
  logic signed [DW-1:0] delta_w;
  logic signed [POS_BITS-1:0] acc_sel_w;
  logic signed [SW-1:0] sum_w;
  logic signed [POS_BITS-1:0] sat_w;

  assign cfg_if.ready = 1'b1;
  assign q_ready      = (state_r == S_IDLE);
  assign pop_w        = q_ctl.valid && q_ready;
  assign out_load_w   = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  // Rotation stage: one shift-add iteration per cycle.
  assign dx_w   = y_r >>> iter_r;
  assign dy_w   = x_r >>> iter_r;
  assign atan_w = $signed({2'b00, poi_pkg::ATAN_TBL[iter_r]});

  always_comb begin
    unique case (quad_r)
      2'd0: begin
        c_w = x_r;
        s_w = y_r;
      end
      2'd1: begin
        c_w = -y_r;
        s_w = x_r;
      end
      2'd2: begin
        c_w = -x_r;
        s_w = -y_r;
      end
      default: begin
        c_w = y_r;
        s_w = -x_r;
      end
    endcase
  end

  assign mc_w = (state_r == S_MULX) ? c_w : s_w;
  assign md_w = (state_r == S_MULX) ? s_w : c_w;

  // The x component is a difference of products, the y component a sum.
  assign comb_w = (state_r == S_MULY) ? ((MW+1)'(pa_r) - (MW+1)'(pb_r))
                                      : ((MW+1)'(pa_r) + (MW+1)'(pb_r));
  assign rnd_w  = comb_w + (MW+1)'(1 << 13);
  assign v16_w  = rnd_w[VW+13:14];

  assign ms_w    = (state_r == S_SUMY) ? vx_r : vy_r;
  assign prr_w   = pr_r + PW'(1 << 23);
  assign delta_w = prr_w[PW-1:poi_pkg::SCALE_W];

  assign acc_sel_w = (state_r == S_SCLY) ? x_acc_r : y_acc_r;
  assign sum_w     = SW'(acc_sel_w) + SW'(delta_w);

  always_comb begin
    priority if (sum_w > SW'(POS_MAX)) begin
      sat_w = POS_MAX;
    end else if (sum_w < SW'(POS_MIN)) begin
      sat_w = POS_MIN;
    end else begin
      sat_w = sum_w[POS_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_w) begin
          state_nxt = q_ctl.is_set ? S_DONE : S_ROT;
        end
      end
      S_ROT: begin
        if (iter_r == IW'(poi_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_MULX;
        end
      end
      S_MULX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_SUMY;
      S_SUMY: state_nxt = S_SCLY;
      S_SCLY: state_nxt = S_ACCY;
      S_ACCY: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load_w) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      scale_r     <= poi_pkg::SCALE_RESET;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        scale_r <= cfg_if.pulse_scale;
      end
      if (state_r == S_ROT) begin
        iter_r <= iter_r + IW'(1);
      end else begin
        iter_r <= '0;
      end
      if (pop_w && q_ctl.is_set) begin
        x_acc_r   <= q_set_x;
        y_acc_r   <= q_set_y;
        heading_r <= q_heading;
      end
      if (state_r == S_SCLY) begin
        x_acc_r <= sat_w;
      end
      if (state_r == S_ACCY) begin
        y_acc_r   <= sat_w;
        heading_r <= cur_head_r;
      end
      if (out_load_w) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_w) begin
      cur_set_r  <= q_ctl.is_set;
      quad_r     <= q_ctl.quad;
      ex_r       <= q_ex;
      ey_r       <= q_ey;
      cur_head_r <= q_heading;
      x_r        <= poi_pkg::CORDIC_X0;
      y_r        <= '0;
      z_r        <= CW'(q_z0);
    end
    unique case (state_r)
      S_ROT: begin
        if (z_r[CW-1]) begin
          x_r <= x_r + dx_w;
          y_r <= y_r - dy_w;
          z_r <= z_r + atan_w;
        end else begin
          x_r <= x_r - dx_w;
          y_r <= y_r + dy_w;
          z_r <= z_r - atan_w;
        end
      end
      S_MULX, S_MULY: begin
        pa_r <= ex_r * mc_w;
        pb_r <= ey_r * md_w;
        if (state_r == S_MULY) begin
          vx_r <= v16_w;
        end
      end
      S_SUMY: begin
        vy_r <= v16_w;
        pr_r <= ms_w * $signed({1'b0, scale_r});
      end
      S_SCLY: begin
        pr_r <= ms_w * $signed({1'b0, scale_r});
      end
      default: begin
      end
    endcase
    if (out_load_w) begin
      pos_x_r    <= x_acc_r;
      pos_y_r    <= y_acc_r;
      head_out_r <= heading_r;
      set_done_r <= cur_set_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pos_x       = pos_x_r;
  assign out_if.pos_y       = pos_y_r;
  assign out_if.heading_out = head_out_r;
  assign out_if.set_done    = set_done_r;

endmodule

// ----- hw/rtl/planar_odometry_integrator.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose keeper built from a queueing front end and a rotate,
// scale and accumulate back end.
// ----------------------------------------------------------------------------
// Usage: each request on in_if either integrates one period of encoder
// pulses, rotated by the binary heading angle and scaled by pulse_scale,
// into the saturating x and y position, or loads the pose directly. Every
// request returns exactly one result on out_if with the pose after it.
// cfg_if writes pulse_scale and is always ready; write it while idle.
// Back end: an integrate request is taken from the queue, runs 16 iterations
// of the single CORDIC shift-add stage and five multiply and accumulate
// steps, and then loads the result register. A set request is taken from
// the queue and loads the result register directly. The back end takes no
// new request until it has loaded the result register.
// The two-entry queue keeps accepting requests while the back end works.
// When the receiver stalls, the result is held in the output register and
// the back end waits; the queue then fills and in_if.ready drops.
// Reset clears the pose and heading to zero and pulse_scale to 16777.
// ----------------------------------------------------------------------------
`include "planar_odometry_integrator_macros.svh"

module planar_odometry_integrator #(
  parameter int ANGLE_BITS = poi_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS   = poi_pkg::POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  poi_in_if.sink     in_if,
  poi_cfg_if.sink    cfg_if,
  poi_out_if.source  out_if
);

  poi_pkg::poi_qctl_t                 q_ctl;
  logic                               q_ready;
  logic signed [poi_pkg::ENC_W-1:0]   q_ex;
  logic signed [poi_pkg::ENC_W-1:0]   q_ey;
  logic signed [poi_pkg::PHASE_W-1:0] q_z0;
  logic signed [poi_pkg::HEAD_W-1:0]  q_heading;
  logic signed [POS_BITS-1:0]         q_set_x;
  logic signed [POS_BITS-1:0]         q_set_y;

  poi_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .POS_BITS   (POS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .q_ctl     (q_ctl),
    .q_ready   (q_ready),
    .q_ex      (q_ex),
    .q_ey      (q_ey),
    .q_z0      (q_z0),
    .q_heading (q_heading),
    .q_set_x   (q_set_x),
    .q_set_y   (q_set_y)
  );

  poi_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (q_ctl),
    .q_ready   (q_ready),
    .q_ex      (q_ex),
    .q_ey      (q_ey),
    .q_z0      (q_z0),
    .q_heading (q_heading),
    .q_set_x   (q_set_x),
    .q_set_y   (q_set_y),
    .cfg_if    (cfg_if),
    .out_if    (out_if)
  );

  `POI_ASSERT_NEXT(a_pop_busy, clk, rst_n, q_ctl.valid && q_ready, !q_ready,
                   "back end still ready after taking a request")
  `POI_ASSERT_SAME(a_full_nonempty, clk, rst_n, !in_if.ready, q_ctl.valid,
                   "input stalled while the queue is empty")
  `POI_ASSERT_NEXT(a_push_visible, clk, rst_n, in_if.valid && in_if.ready, q_ctl.valid,
                   "accepted request missing from the queue")

endmodule

// ----- dv/planar_odometry_integrator_tb.sv -----
// ----------------------------------------------------------------------------
// Planar odometry integrator testbench
// Drives integrate and set-pose requests through the request channel with
// random gaps and result back-pressure, rewrites pulse_scale between phases,
// and checks every result against a cycle-free model of the CORDIC rotation,
// the scaling, the saturating accumulators and the stored heading.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_tb;
  import poi_pkg::*;

  localparam int ANGLE_W = ANGLE_BITS_DEF;
  localparam int POS_W = POS_BITS_DEF;
  localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
  localparam longint POS_MIN = -POS_MAX - 64'sd1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_SETTLE = 30;
  localparam int BATCH_SIZE = 130;

  typedef struct {
    poi_cmd_t                  command;
    logic signed [ENC_W-1:0]   enc_x;
    logic signed [ENC_W-1:0]   enc_y;
    logic [ANGLE_W-1:0]        angle;
    logic signed [HEAD_W-1:0]  head_deg;
    logic signed [POS_W-1:0]   new_x;
    logic signed [POS_W-1:0]   new_y;
    logic signed [HEAD_W-1:0]  new_head;
  } odo_request_t;

  typedef struct {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [HEAD_W-1:0]  heading;
    logic                      set_done;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n;

  poi_in_if #(.ANGLE_BITS(ANGLE_W), .POS_BITS(POS_W)) in_ch ();
  poi_out_if #(.POS_BITS(POS_W)) out_ch ();
  poi_cfg_if cfg_ch ();

  planar_odometry_integrator #(
    .ANGLE_BITS(ANGLE_W),
    .POS_BITS(POS_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .cfg_if(cfg_ch),
    .out_if(out_ch)
  );

  pose_t expected_poses[$];
  longint odo_x;
  longint odo_y;
  logic [HEAD_W-1:0] odo_head;
  logic [SCALE_W-1:0] odo_scale;

  int error_count = 0;
  int results_checked = 0;
  int integrate_count = 0;
  int set_count = 0;
  int scale_settings = 0;
  int cycle_count = 0;
  bit steady_source = 1'b0;
  bit steady_sink = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void cordic_sincos(input logic [ANGLE_W-1:0] angle,
                                        output longint cos_v, output longint sin_v);
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] z_raw;
    logic [1:0] quad;
    longint x, y, z, dx, dy;
    phase = PHASE_W'(angle) << (PHASE_W - ANGLE_W);
    quad = 2'((phase + 32'h2000_0000) >> 30);
    z_raw = phase - {quad, 30'b0};
    z = longint'($signed(z_raw));
    x = longint'(CORDIC_X0);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TBL[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TBL[i]);
      end
    end
    case (quad)
      2'd0: begin
        cos_v = x;
        sin_v = y;
      end
      2'd1: begin
        cos_v = -y;
        sin_v = x;
      end
      2'd2: begin
        cos_v = -x;
        sin_v = -y;
      end
      default: begin
        cos_v = y;
        sin_v = -x;
      end
    endcase
  endfunction

  function automatic longint scaled_step(input longint v30, input logic [SCALE_W-1:0] scale);
    longint v16, prod;
    v16 = (v30 + 64'sd8192) >>> 14;
    prod = v16 * longint'(scale);
    return (prod + 64'sd8388608) >>> 24;
  endfunction

  function automatic longint saturate_pos(input longint acc, input longint delta);
    longint sum;
    sum = acc + delta;
    if (sum > POS_MAX) return POS_MAX;
    if (sum < POS_MIN) return POS_MIN;
    return sum;
  endfunction

  function automatic void predict_pose(input odo_request_t r);
    longint c, s, ex, ey;
    pose_t p;
    if (r.command == CMD_SET) begin
      odo_x = longint'(r.new_x);
      odo_y = longint'(r.new_y);
      odo_head = r.new_head;
    end else begin
      ex = longint'(r.enc_x);
      ey = longint'(r.enc_y);
      cordic_sincos(r.angle, c, s);
      odo_x = saturate_pos(odo_x, scaled_step(ex * c - ey * s, odo_scale));
      odo_y = saturate_pos(odo_y, scaled_step(ex * s + ey * c, odo_scale));
      odo_head = r.head_deg;
    end
    p.pos_x = odo_x[POS_W-1:0];
    p.pos_y = odo_y[POS_W-1:0];
    p.heading = odo_head;
    p.set_done = (r.command == CMD_SET);
    expected_poses.push_back(p);
  endfunction

  function automatic logic signed [ENC_W-1:0] pick_pulses();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return ENC_W'($signed($urandom_range(200)) - 100);
      default: return ENC_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [HEAD_W-1:0] pick_heading();
    if ($urandom_range(99) < 85) return HEAD_W'($signed($urandom_range(92160)) - 46080);
    return HEAD_W'($urandom);
  endfunction

  function automatic logic signed [POS_W-1:0] pick_position();
    case ($urandom_range(9))
      0: return POS_W'(POS_MAX - longint'($urandom_range(1 << 20)));
      1: return POS_W'(POS_MIN + longint'($urandom_range(1 << 20)));
      2, 3: return POS_W'($signed($urandom_range(1 << 24)) - (1 << 23));
      default: return POS_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic odo_request_t random_request(input int set_pct);
    odo_request_t r;
    r.command = ($urandom_range(99) < set_pct) ? CMD_SET : CMD_INTEGRATE;
    r.enc_x = pick_pulses();
    r.enc_y = pick_pulses();
    r.angle = ANGLE_W'($urandom);
    r.head_deg = pick_heading();
    r.new_x = pick_position();
    r.new_y = pick_position();
    r.new_head = pick_heading();
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady_source || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  task automatic send_request(input odo_request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= r.command;
    in_ch.enc_x_pulses <= r.enc_x;
    in_ch.enc_y_pulses <= r.enc_y;
    in_ch.heading_angle <= r.angle;
    in_ch.heading_degrees <= r.head_deg;
    in_ch.set_x <= r.new_x;
    in_ch.set_y <= r.new_y;
    in_ch.set_heading <= r.new_head;
    do @(posedge clk); while (!in_ch.ready);
    predict_pose(r);
    if (r.command == CMD_SET) set_count++;
    else integrate_count++;
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_pulse_scale(input logic [SCALE_W-1:0] value);
    drain_pipeline();
    cfg_ch.valid <= 1'b1;
    cfg_ch.pulse_scale <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    odo_scale = value;
    scale_settings++;
  endtask

  task automatic test_integrate_extremes();
    odo_request_t r;
    logic [ANGLE_W-1:0] angles [9];
    logic signed [ENC_W-1:0] ex_list [4];
    logic signed [ENC_W-1:0] ey_list [4];
    logic signed [HEAD_W-1:0] head_list [4];
    angles = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
               16'h8000, 16'hC000, 16'hE000, 16'hFFFF};
    ex_list = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
    ey_list = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
    head_list = '{17'sd46080, -17'sd46080, 17'h10000, 17'h0FFFF};
    for (int i = 0; i < 9; i++) begin
      r = random_request(0);
      r.angle = angles[i];
      r.enc_x = (i == 8) ? 16'sh0000 : ex_list[i % 4];
      r.enc_y = (i == 8) ? 16'sh0000 : ey_list[i % 4];
      r.head_deg = head_list[i % 4];
      send_request(r);
    end
  endtask

  task automatic test_set_pose();
    odo_request_t r;
    r = random_request(100);
    r.new_x = POS_W'(POS_MAX);
    r.new_y = POS_W'(POS_MIN);
    r.new_head = 17'sd46080;
    send_request(r);
    r = random_request(100);
    r.new_x = POS_W'(POS_MIN);
    r.new_y = POS_W'(POS_MAX);
    r.new_head = -17'sd46080;
    send_request(r);
    r = random_request(100);
    r.new_head = 17'h1FFFF;
    send_request(r);
    r = random_request(100);
    r.new_x = '0;
    r.new_y = '0;
    r.new_head = 17'h10000;
    send_request(r);
  endtask

  task automatic test_saturation();
    odo_request_t r;
    write_pulse_scale({SCALE_W{1'b1}});
    r = random_request(100);
    r.new_x = POS_W'(POS_MAX - 64'sd1000);
    r.new_y = POS_W'(POS_MAX - 64'sd5);
    send_request(r);
    r = random_request(0);
    r.enc_x = 16'sh7FFF;
    r.enc_y = 16'sh0000;
    r.angle = 16'h0000;
    send_request(r);
    r.angle = 16'h4000;
    send_request(r);
    r.angle = 16'h0000;
    send_request(r);
    r = random_request(100);
    r.new_x = POS_W'(POS_MIN + 64'sd1000);
    r.new_y = POS_W'(POS_MIN + 64'sd5);
    send_request(r);
    r = random_request(0);
    r.enc_x = 16'sh8000;
    r.enc_y = 16'sh0000;
    r.angle = 16'h0000;
    send_request(r);
    r.angle = 16'h4000;
    send_request(r);
  endtask

  task automatic test_random_traffic();
    logic [SCALE_W-1:0] scales [5];
    scales = '{{SCALE_W{1'b1}}, '0, SCALE_W'($urandom), SCALE_RESET, SCALE_W'($urandom)};
    for (int s = 0; s < 5; s++) begin
      write_pulse_scale(scales[s]);
      for (int n = 0; n < BATCH_SIZE; n++) begin
        steady_source = (s % 2 == 0) && (n < 25);
        steady_sink = (s % 2 == 1) && (n < 25);
        send_request(random_request(20));
      end
      steady_source = 1'b0;
      steady_sink = 1'b0;
    end
  endtask

  initial begin
    int hold;
    logic level;
    out_ch.ready <= 1'b0;
    hold = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        case ($urandom_range(19))
          0: begin
            level = 1'b0;
            hold = $urandom_range(20, 80);
          end
          1, 2, 3, 4, 5: begin
            level = 1'b0;
            hold = $urandom_range(1, 3);
          end
          default: begin
            level = 1'b1;
            hold = $urandom_range(1, 12);
          end
        endcase
      end
      hold--;
      out_ch.ready <= steady_sink || level;
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: result with no request waiting: pos_x %h pos_y %h heading %h set_done %b",
                 $time, out_ch.pos_x, out_ch.pos_y, out_ch.heading_out, out_ch.set_done);
        error_count++;
      end else begin
        want = expected_poses.pop_front();
        results_checked++;
        if (out_ch.pos_x !== want.pos_x) begin
          $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, out_ch.pos_x);
          error_count++;
        end
        if (out_ch.pos_y !== want.pos_y) begin
          $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, out_ch.pos_y);
          error_count++;
        end
        if (out_ch.heading_out !== want.heading) begin
          $display("%0t: heading_out expected %h actual %h", $time, want.heading,
                   out_ch.heading_out);
          error_count++;
        end
        if (out_ch.set_done !== want.set_done) begin
          $display("%0t: set_done expected %b actual %b", $time, want.set_done,
                   out_ch.set_done);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_poses.size());
      $display("planar_odometry_integrator_tb failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_INTEGRATE;
    in_ch.enc_x_pulses <= '0;
    in_ch.enc_y_pulses <= '0;
    in_ch.heading_angle <= '0;
    in_ch.heading_degrees <= '0;
    in_ch.set_x <= '0;
    in_ch.set_y <= '0;
    in_ch.set_heading <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.pulse_scale <= '0;
    odo_x = 0;
    odo_y = 0;
    odo_head = '0;
    odo_scale = SCALE_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_integrate_extremes();
    test_set_pose();
    test_saturation();
    test_random_traffic();

    drain_pipeline();
    if (expected_poses.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_poses.size());
      error_count++;
    end
    $display("Checked %0d results from %0d integrate and %0d set requests", results_checked,
             integrate_count, set_count);
    $display("over %0d pulse_scale settings plus the reset value, with random stalls.",
             scale_settings);
    if (error_count == 0) begin
      $display("planar_odometry_integrator_tb passed");
    end else begin
      $display("planar_odometry_integrator_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/poi_pkg.sv
hw/rtl/poi_ifs.sv
hw/rtl/poi_front.sv
hw/rtl/poi_back.sv
hw/rtl/planar_odometry_integrator.sv
dv/planar_odometry_integrator_tb.sv
